FILE: src/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

  localparam int DEPTH    = 16;
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // element count holds 0..DEPTH
  localparam int CNT_W = $clog2(DEPTH + 1);
  // position arithmetic width, one spare bit so count+1 never wraps
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [CMP_W-1:0]          cmp_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_END   = 3'd1,
    ACT_INS_POS   = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_END   = 3'd4,
    ACT_DEL_POS   = 3'd5,
    ACT_SEARCH    = 3'd6
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // per-cell update control
  typedef struct packed {
    logic load;        // take the new element
    logic from_left;   // shift toward the end (insert)
    logic from_right;  // shift toward the front (delete)
  } cell_ctl_t;

endpackage

FILE: src/ple_if.sv
`timescale 1ns / 1ps

interface ple_req_if;
  import ple_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]      position;

  modport source (output valid, output action, output value, output position, input ready);
  modport sink   (input valid, input action, input value, input position, output ready);
endinterface

interface ple_rsp_if;
  import ple_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_W-1:0]        count;
  logic                      found;
  logic [COUNT_W-1:0]        found_position;
  logic signed [VALUE_W-1:0] removed_value;

  modport source (output valid, output status, output count, output found,
                  output found_position, output removed_value, input ready);
  modport sink   (input valid, input status, input count, input found,
                  input found_position, input removed_value, output ready);
endinterface

FILE: src/ple_cell.sv
`timescale 1ns / 1ps

module ple_cell (
  input  logic              clk,
  input  ple_pkg::cell_ctl_t ctl,
  input  ple_pkg::value_t   new_val,
  input  ple_pkg::value_t   left_val,
  input  ple_pkg::value_t   right_val,
  input  ple_pkg::value_t   key,
  input  logic              live,
  input  logic              hit_in,
  output ple_pkg::value_t   val,
  output logic              hit_out,
  output logic              first
);
  import ple_pkg::*;

  logic match;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val <= new_val;
    end else if (ctl.from_left) begin
      val <= left_val;
    end else if (ctl.from_right) begin
      val <= right_val;
    end
  end

  // search hit travels toward the end so only the earliest match reports
  assign match   = live && (val == key);
  assign first   = match && !hit_in;
  assign hit_out = hit_in || match;

endmodule

FILE: src/positional_list_engine.sv
`timescale 1ns / 1ps
// the response is registered and becomes valid in the cycle after the request is accepted
// throughput: one request per cycle; every cell shifts or compares in the same cycle
// a stalled response holds the next request back only until it is taken
// reset clears the element count and the response valid; cell contents stay
// unknown and are never observed before being written

module positional_list_engine (
  input  logic     clk,
  input  logic     rst,
  ple_req_if.sink  req,
  ple_rsp_if.source rsp
);
  import ple_pkg::*;

  logic [CNT_W-1:0] element_count;
  logic [CNT_W-1:0] element_count_next;
  logic             out_valid;
  logic             accept;

  cmp_t    cnt;
  cmp_t    pos_ext;
  cmp_t    eff_pos;
  cmp_t    idx;
  cmp_t    cnt_after;
  cmp_t    fpos;
  status_t status;
  logic    do_ins;
  logic    do_del;
  logic    do_search;
  value_t  removed;

  value_t    cell_val [DEPTH];
  cell_ctl_t cell_ctl [DEPTH];
  logic      first    [DEPTH];
  logic      hit      [DEPTH+1];

  status_t out_status;
  cmp_t    out_count;
  logic    out_found;
  cmp_t    out_fpos;
  value_t  out_removed;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign cnt     = cmp_t'(element_count);
  assign pos_ext = cmp_t'(req.position);

  // request decode
  always_comb begin
    eff_pos   = pos_ext;
    status    = ST_OK;
    do_ins    = 1'b0;
    do_del    = 1'b0;
    do_search = 1'b0;
    case (action_t'(req.action))
      ACT_INS_FRONT, ACT_INS_END, ACT_INS_POS: begin
        if (action_t'(req.action) == ACT_INS_FRONT) begin
          eff_pos = cmp_t'(1);
        end else if (action_t'(req.action) == ACT_INS_END) begin
          eff_pos = cnt + cmp_t'(1);
        end
        if (eff_pos == '0 || eff_pos > cnt + cmp_t'(1)) begin
          status = ST_BADPOS;
        end else if (cnt >= cmp_t'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      ACT_DEL_FRONT, ACT_DEL_END, ACT_DEL_POS: begin
        if (action_t'(req.action) == ACT_DEL_FRONT) begin
          eff_pos = cmp_t'(1);
        end else if (action_t'(req.action) == ACT_DEL_END) begin
          eff_pos = cnt;
        end
        if (cnt == '0) begin
          status = ST_EMPTY;
        end else if (eff_pos == '0 || eff_pos > cnt) begin
          status = ST_BADPOS;
        end else begin
          do_del = 1'b1;
        end
      end
      ACT_SEARCH: begin
        if (cnt == '0) begin
          status = ST_EMPTY;
        end else begin
          do_search = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign idx = eff_pos - cmp_t'(1);

  assign hit[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    value_t left_val;
    value_t right_val;

    if (g == 0) begin : g_head
      assign left_val = req.value;
    end else begin : g_body
      assign left_val = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = cell_val[g+1];
    end

    assign cell_ctl[g].load       = accept && do_ins && (idx == cmp_t'(g));
    assign cell_ctl[g].from_left  = accept && do_ins && (cmp_t'(g) > idx);
    assign cell_ctl[g].from_right = accept && do_del && (cmp_t'(g) >= idx);

    ple_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[g]),
      .new_val   (req.value),
      .left_val  (left_val),
      .right_val (right_val),
      .key       (req.value),
      .live      (cmp_t'(g) < cnt),
      .hit_in    (hit[g]),
      .val       (cell_val[g]),
      .hit_out   (hit[g+1]),
      .first     (first[g])
    );
  end

  // pick the removed element and the first match position
  always_comb begin
    removed = '0;
    fpos    = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (do_del && idx == cmp_t'(i)) begin
        removed = removed | cell_val[i];
      end
      if (do_search && first[i]) begin
        fpos = fpos | cmp_t'(i + 1);
      end
    end
  end

  always_comb begin
    if (do_ins) begin
      cnt_after = cnt + cmp_t'(1);
    end else if (do_del) begin
      cnt_after = cnt - cmp_t'(1);
    end else begin
      cnt_after = cnt;
    end
  end

  assign element_count_next = accept ? cnt_after[CNT_W-1:0] : element_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      element_count <= element_count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status  <= status;
      out_count   <= cnt_after;
      out_found   <= do_search && hit[DEPTH];
      out_fpos    <= fpos;
      out_removed <= removed;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.count          = out_count[COUNT_W-1:0];
  assign rsp.found          = out_found;
  assign rsp.found_position = out_fpos[COUNT_W-1:0];
  assign rsp.removed_value  = out_removed;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmp_t'(element_count) <= cmp_t'(DEPTH))
    else $error("element count above depth");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    accept && do_ins |=> element_count == $past(element_count) + 1'b1)
    else $error("insert did not grow the list");

  a_del_shrinks: assert property (@(posedge clk) disable iff (rst)
    accept && do_del |=> element_count == $past(element_count) - 1'b1)
    else $error("delete did not shrink the list");

  a_found_pos: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> rsp.status == ST_OK && out_fpos != '0
      && out_fpos <= out_count)
    else $error("found flag without a valid position");

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    accept && do_ins |-> !(cell_ctl[0].load && cell_ctl[0].from_left))
    else $error("head cell both loads and shifts");

endmodule
